### hw/rtl/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// shared types and constants of the encoder count and speed meter
// ----------------------------------------------------------------------------
package ecsm_pkg;

  localparam int CMD_W      = 2;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int ELAPSED_W  = 16;
  localparam int DEN_W      = 32;
  localparam int SPEED_W    = 24;
  localparam int TCOUNT_W   = 32;
  localparam int SCALE_SH_W = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_REV = 1'b0,
    CFG_PERIOD_MS     = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MAG,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic start;
    logic neg;
  } sdiv_req_t;

  localparam logic [CFG_W-1:0]     TPR_RESET    = 16'd1;
  localparam logic [CFG_W-1:0]     PERIOD_RESET = 16'd20;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 16'hFFFF;
  localparam logic [SPEED_W-1:0]   SPEED_MAX    = 24'h7FFFFF;
  localparam logic [SPEED_W-1:0]   SPEED_MIN    = 24'h800000;

endpackage

### hw/rtl/encoder_count_speed_meter_core.sv
// ----------------------------------------------------------------------------
// encoder_count_speed_meter_core
// quadrature encoder counter with periodic speed measurement
// ----------------------------------------------------------------------------
// usage
//   in_*  : one transaction per event: channel A edge (with sampled A and B
//           levels), millisecond tick, or count clear
//   out_* : one transaction per input event with the count, the speed in
//           revolutions per second (signed, SPEED_FRAC_BITS fraction bits)
//           and a flag set when that event recomputed the speed
//   cfg_* : single-cycle register writes, only while the block is idle
// sequence: an accepted event passes through the EXEC and PUSH states to the
//   output register; a tick that recomputes the speed also passes MAG, MUL1,
//   MUL2 and the bit-serial divider before PUSH
// events: a new event is taken only in the idle state, once the previous one
//   has left its final step; one event in flight plus one finished result in
//   the output register
// reset: count, saved count, elapsed time and speed clear to zero, counts
//   per revolution to 1 and period to 20 ms
// a stalled receiver holds the result; the next event is still taken and
//   waits in its final step until the output register frees up
// ----------------------------------------------------------------------------
module encoder_count_speed_meter_core #(
  parameter int COUNT_WIDTH     = 32,
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ecsm_pkg::CMD_W-1:0]           in_cmd,
  input  logic                                 in_pin_a,
  input  logic                                 in_pin_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ecsm_pkg::TCOUNT_W-1:0] out_tick_count,
  output logic signed [ecsm_pkg::SPEED_W-1:0]  out_speed_rps,
  output logic                                 out_speed_updated,
  input  logic                                 cfg_we,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ecsm_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int CW     = COUNT_WIDTH;
  localparam int PROD_W = COUNT_WIDTH + ecsm_pkg::SCALE_SH_W;
  localparam int NUM_W  = PROD_W + SPEED_FRAC_BITS;
  localparam int EW     = ecsm_pkg::ELAPSED_W;
  localparam int SW     = ecsm_pkg::SPEED_W;
  localparam int TW     = ecsm_pkg::TCOUNT_W;

  ecsm_pkg::state_t             state_r;
  ecsm_pkg::state_t             state_nxt;
  ecsm_pkg::cmd_t               cmd_r;
  logic                         pin_a_r;
  logic                         pin_b_r;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                count_last_r;
  logic [EW-1:0]                elapsed_r;
  logic [SW-1:0]                speed_r;
  logic [ecsm_pkg::CFG_W-1:0]   tpr_r;
  logic [ecsm_pkg::CFG_W-1:0]   period_r;
  logic [CW-1:0]                work_r;
  logic                         neg_r;
  logic [PROD_W-1:0]            prod_r;
  logic [ecsm_pkg::DEN_W-1:0]   den_r;
  logic                         upd_r;
  logic                         out_valid_r;
  logic [TW-1:0]                out_count_r;
  logic [SW-1:0]                out_speed_r;
  logic                         out_upd_r;

  logic [EW-1:0]                elapsed_inc;
  logic                         tick_due;
  logic [ecsm_pkg::CFG_W-1:0]   cfg_val;
  logic [PROD_W-1:0]            prod_fin;
  logic [NUM_W-1:0]             div_num;
  ecsm_pkg::sdiv_req_t          div_req;
  logic                         div_done;
  logic [SW-1:0]                div_quo;
  logic                         out_free;
  logic [TW-1:0]                count_ext;

  assign elapsed_inc = (elapsed_r == ecsm_pkg::ELAPSED_MAX) ? elapsed_r
                                                            : elapsed_r + 1'b1;
  assign tick_due    = (elapsed_inc >= period_r);
  assign cfg_val     = (cfg_wdata == '0) ? ecsm_pkg::CFG_W'(1) : cfg_wdata;
  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == ecsm_pkg::ST_IDLE);

  // x1000 = x1024 - x16 - x8
  assign prod_fin = prod_r - (PROD_W'(work_r) << 3);
  assign div_num  = NUM_W'(prod_fin) << SPEED_FRAC_BITS;

  generate
    if (COUNT_WIDTH >= TW) begin : g_trunc
      assign count_ext = count_r[TW-1:0];
    end else begin : g_sext
      assign count_ext = {{(TW - CW){count_r[CW-1]}}, count_r};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecsm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.neg   = neg_r;
    case (state_r)
      ecsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ecsm_pkg::ST_EXEC;
        end
      end
      ecsm_pkg::ST_EXEC: begin
        if (cmd_r == ecsm_pkg::CMD_TICK && tick_due) begin
          state_nxt = ecsm_pkg::ST_MAG;
        end else begin
          state_nxt = ecsm_pkg::ST_PUSH;
        end
      end
      ecsm_pkg::ST_MAG: begin
        state_nxt = ecsm_pkg::ST_MUL1;
      end
      ecsm_pkg::ST_MUL1: begin
        state_nxt = ecsm_pkg::ST_MUL2;
      end
      ecsm_pkg::ST_MUL2: begin
        div_req.start = 1'b1;
        state_nxt     = ecsm_pkg::ST_DIV;
      end
      ecsm_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ecsm_pkg::ST_PUSH;
        end
      end
      ecsm_pkg::ST_PUSH: begin
        if (out_free) begin
          state_nxt = ecsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ecsm_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpr_r    <= ecsm_pkg::TPR_RESET;
      period_r <= ecsm_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ecsm_pkg::CFG_TICKS_PER_REV: tpr_r    <= cfg_val;
        ecsm_pkg::CFG_PERIOD_MS:     period_r <= cfg_val;
        default: begin
        end
      endcase
    end
  end

  // counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      count_last_r <= '0;
      elapsed_r    <= '0;
      speed_r      <= '0;
    end else begin
      if (state_r == ecsm_pkg::ST_EXEC) begin
        case (cmd_r)
          ecsm_pkg::CMD_EDGE: begin
            count_r <= (pin_a_r == pin_b_r) ? count_r + 1'b1 : count_r - 1'b1;
          end
          ecsm_pkg::CMD_TICK: begin
            if (tick_due) begin
              count_last_r <= count_r;
              elapsed_r    <= '0;
            end else begin
              elapsed_r <= elapsed_inc;
            end
          end
          ecsm_pkg::CMD_CLEAR: begin
            count_r      <= '0;
            count_last_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (state_r == ecsm_pkg::ST_DIV && div_done) begin
        speed_r <= div_quo;
      end
    end
  end

  // item and speed datapath
  always_ff @(posedge clk) begin
    if (state_r == ecsm_pkg::ST_IDLE && in_valid) begin
      cmd_r   <= ecsm_pkg::cmd_t'(in_cmd);
      pin_a_r <= in_pin_a;
      pin_b_r <= in_pin_b;
    end
    case (state_r)
      ecsm_pkg::ST_EXEC: begin
        upd_r  <= (cmd_r == ecsm_pkg::CMD_TICK) && tick_due;
        work_r <= count_r - count_last_r;
        den_r  <= ecsm_pkg::DEN_W'(tpr_r) * ecsm_pkg::DEN_W'(elapsed_inc);
      end
      ecsm_pkg::ST_MAG: begin
        neg_r  <= work_r[CW-1];
        work_r <= work_r[CW-1] ? (CW'(0) - work_r) : work_r;
      end
      ecsm_pkg::ST_MUL1: begin
        prod_r <= (PROD_W'(work_r) << ecsm_pkg::SCALE_SH_W) - (PROD_W'(work_r) << 4);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ecsm_pkg::ST_PUSH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ecsm_pkg::ST_PUSH && out_free) begin
      out_count_r <= count_ext;
      out_speed_r <= speed_r;
      out_upd_r   <= upd_r;
    end
  end

  ecsm_sdiv #(
    .NUM_W (NUM_W)
  ) u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid         = out_valid_r;
  assign out_tick_count    = out_count_r;
  assign out_speed_rps     = out_speed_r;
  assign out_speed_updated = out_upd_r;

endmodule

### hw/rtl/ecsm_sdiv.sv
// ----------------------------------------------------------------------------
// ecsm_sdiv
// bit-serial restoring divider, one dividend bit per cycle, saturating
// signed result
// ----------------------------------------------------------------------------
module ecsm_sdiv #(
  parameter int NUM_W = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ecsm_pkg::sdiv_req_t           req,
  input  logic [NUM_W-1:0]              num,
  input  logic [ecsm_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [ecsm_pkg::SPEED_W-1:0]  quo
);

  localparam int DW    = ecsm_pkg::DEN_W;
  localparam int SW    = ecsm_pkg::SPEED_W;
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DW-1:0]    den_r;
  logic [DW-1:0]    rem_r;
  logic [SW-2:0]    q_r;
  logic             ovf_r;
  logic             neg_r;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;
  logic [DW-1:0]    rem_nxt;
  logic [SW-1:0]    mag_q;

  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= num;
      den_r <= den;
      neg_r <= req.neg;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[SW-3:0], ge};
      ovf_r <= ovf_r | q_r[SW-2];
    end
  end

  assign mag_q = {1'b0, q_r};

  always_comb begin
    if (ovf_r) begin
      quo = neg_r ? ecsm_pkg::SPEED_MIN : ecsm_pkg::SPEED_MAX;
    end else begin
      quo = neg_r ? (SW'(0) - mag_q) : mag_q;
    end
  end

  assign done = done_r;

endmodule

### hw/rtl/ecsm_checker.sv
// ----------------------------------------------------------------------------
// ecsm_checker
// port-level checks of the encoder count and speed meter
// ----------------------------------------------------------------------------
module ecsm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ecsm_pkg::TCOUNT_W-1:0] out_tick_count,
  input logic signed [ecsm_pkg::SPEED_W-1:0]  out_speed_rps,
  input logic                                 out_speed_updated
);

  logic [1:0]                       pend_r;
  logic [ecsm_pkg::SPEED_W-1:0]     last_speed_r;
  logic                             in_acc;
  logic                             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      last_speed_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        last_speed_r <= out_speed_rps;
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_count)
      && $stable(out_speed_rps) && $stable(out_speed_updated))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending transaction");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many transactions in flight");

  a_speed_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_speed_updated |-> out_speed_rps == last_speed_r)
    else $error("speed changed without an update");

endmodule

bind encoder_count_speed_meter_core ecsm_checker u_ecsm_checker (.*);

### tb/encoder_count_speed_meter_core_tb.sv
// ----------------------------------------------------------------------------
// encoder_count_speed_meter_core_tb
// self-checking bench for the encoder count and speed meter core
// ----------------------------------------------------------------------------
// A clocked driver feeds encoder events from a pending queue, in random
// bursts with random gaps. A clocked monitor stalls the result channel on a
// changing pattern and checks every result field against a bench-side
// predictor of count, elapsed time and period speed. The run steps through
// several register settings, written only while the core is idle, starting
// with random events at the reset settings and a short directed sequence,
// and continuing with random edge runs, millisecond ticks and clears.
// ----------------------------------------------------------------------------
module encoder_count_speed_meter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SPEED_FRAC  = 8;
  localparam int          RUN_LIMIT   = 1_000_000;
  localparam logic [63:0] SPEED_SCALE = 64'd1000 << SPEED_FRAC;
  localparam logic [63:0] SPEED_SPAN  = 64'd8388608;

  typedef struct {
    ecsm_pkg::cmd_t cmd;
    logic           pin_a;
    logic           pin_b;
  } enc_event_t;

  typedef struct {
    logic [ecsm_pkg::TCOUNT_W-1:0] count;
    logic [ecsm_pkg::SPEED_W-1:0]  speed;
    logic                          updated;
  } meter_reading_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [ecsm_pkg::CMD_W-1:0]     in_cmd = ecsm_pkg::CMD_NONE;
  logic                           in_pin_a = 1'b0;
  logic                           in_pin_b = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [ecsm_pkg::TCOUNT_W-1:0]  out_tick_count;
  logic [ecsm_pkg::SPEED_W-1:0]   out_speed_rps;
  logic                           out_speed_updated;
  logic                           cfg_we = 1'b0;
  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index = ecsm_pkg::CFG_TICKS_PER_REV;
  logic [ecsm_pkg::CFG_W-1:0]     cfg_wdata = '0;

  enc_event_t     event_q[$];
  meter_reading_t reading_q[$];
  enc_event_t     cur_event;
  meter_reading_t seen_reading;

  // bench copy of the meter state and registers
  logic [ecsm_pkg::TCOUNT_W-1:0]  cnt_now = '0;
  logic [ecsm_pkg::TCOUNT_W-1:0]  cnt_saved = '0;
  logic [ecsm_pkg::ELAPSED_W-1:0] elapsed_ms = '0;
  logic [ecsm_pkg::SPEED_W-1:0]   speed_now = '0;
  logic [ecsm_pkg::CFG_W-1:0]     tpr_cfg = ecsm_pkg::TPR_RESET;
  logic [ecsm_pkg::CFG_W-1:0]     period_cfg = ecsm_pkg::PERIOD_RESET;

  int err_count = 0;
  int result_count = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  encoder_count_speed_meter_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_pin_a          (in_pin_a),
    .in_pin_b          (in_pin_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tick_count    (out_tick_count),
    .out_speed_rps     (out_speed_rps),
    .out_speed_updated (out_speed_updated),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [ecsm_pkg::SPEED_W-1:0] period_speed(
    input logic [ecsm_pkg::TCOUNT_W-1:0]  now_cnt,
    input logic [ecsm_pkg::TCOUNT_W-1:0]  old_cnt,
    input logic [ecsm_pkg::CFG_W-1:0]     tpr,
    input logic [ecsm_pkg::ELAPSED_W-1:0] elapsed
  );
    logic [ecsm_pkg::TCOUNT_W-1:0] delta;
    logic [ecsm_pkg::TCOUNT_W-1:0] absd;
    logic                          neg;
    logic [63:0]                   mag;
    logic [63:0]                   den;
    logic [63:0]                   sat_at;
    logic [63:0]                   quo;
    delta = now_cnt - old_cnt;
    neg   = delta[ecsm_pkg::TCOUNT_W-1];
    absd  = neg ? (~delta + 1'b1) : delta;
    mag   = 64'(absd);
    den   = 64'(tpr) * 64'(elapsed);
    if (den == 64'd0) begin
      den = 64'd1;
    end
    sat_at = (SPEED_SPAN * den + SPEED_SCALE - 64'd1) / SPEED_SCALE;
    if (mag >= sat_at) begin
      return neg ? ecsm_pkg::SPEED_MIN : ecsm_pkg::SPEED_MAX;
    end
    quo = (mag * SPEED_SCALE) / den;
    if (neg) begin
      quo = ~quo + 64'd1;
    end
    return quo[ecsm_pkg::SPEED_W-1:0];
  endfunction

  task predict_reading(input enc_event_t ev);
    meter_reading_t r;
    r.updated = 1'b0;
    case (ev.cmd)
      ecsm_pkg::CMD_EDGE: begin
        cnt_now = (ev.pin_a == ev.pin_b) ? cnt_now + 1'b1 : cnt_now - 1'b1;
      end
      ecsm_pkg::CMD_TICK: begin
        if (elapsed_ms != ecsm_pkg::ELAPSED_MAX) begin
          elapsed_ms = elapsed_ms + 1'b1;
        end
        if (elapsed_ms >= period_cfg) begin
          speed_now  = period_speed(cnt_now, cnt_saved, tpr_cfg, elapsed_ms);
          cnt_saved  = cnt_now;
          elapsed_ms = '0;
          r.updated  = 1'b1;
        end
      end
      ecsm_pkg::CMD_CLEAR: begin
        cnt_now   = '0;
        cnt_saved = '0;
      end
      default: begin
      end
    endcase
    r.count = cnt_now;
    r.speed = speed_now;
    reading_q.push_back(r);
  endtask

  task report_error(input string msg);
    $display("mismatch at result %0d: %s", result_count, msg);
    err_count++;
  endtask

  task push_event(input ecsm_pkg::cmd_t cmd, input logic a, input logic b);
    enc_event_t ev;
    ev.cmd   = cmd;
    ev.pin_a = a;
    ev.pin_b = b;
    event_q.push_back(ev);
  endtask

  task wait_idle();
    do begin
      @(negedge clk);
    end while (event_q.size() != 0 || in_valid || reading_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task load_config(input logic [ecsm_pkg::CFG_W-1:0] tpr,
                   input logic [ecsm_pkg::CFG_W-1:0] per);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ecsm_pkg::CFG_TICKS_PER_REV;
    cfg_wdata <= tpr;
    @(posedge clk);
    cfg_index <= ecsm_pkg::CFG_PERIOD_MS;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_we     <= 1'b0;
    tpr_cfg    = (tpr == '0) ? ecsm_pkg::CFG_W'(1) : tpr;
    period_cfg = (per == '0) ? ecsm_pkg::CFG_W'(1) : per;
    @(negedge clk);
  endtask

  // mostly runs of same-direction edges with ticks, plus some raw noise
  task add_random_events(input int n);
    int             added;
    int             run_len;
    int             tick_pct;
    logic           up;
    logic           lvl;
    ecsm_pkg::cmd_t noise_cmd;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 8) begin
        up       = 1'($urandom_range(0, 1));
        run_len  = $urandom_range(1, 60);
        tick_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(1, 100) <= tick_pct) begin
            push_event(ecsm_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          end else begin
            lvl = 1'($urandom_range(0, 1));
            push_event(ecsm_pkg::CMD_EDGE, lvl, up ? lvl : ~lvl);
          end
        end
        added += run_len;
        for (int i = $urandom_range(0, 3); i > 0; i--) begin
          push_event(ecsm_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          added++;
        end
        if ($urandom_range(0, 11) == 0) begin
          push_event(ecsm_pkg::CMD_CLEAR, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          added++;
        end
      end else begin
        for (int i = $urandom_range(1, 10); i > 0; i--) begin
          noise_cmd = ecsm_pkg::cmd_t'(2'($urandom_range(0, 3)));
          push_event(noise_cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          if (noise_cmd != ecsm_pkg::CMD_NONE) begin
            added++;
          end
        end
      end
    end
  endtask

  // input side: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_reading(cur_event);
      end
      if (gap_left > 0 || event_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        cur_event = event_q.pop_front();
        in_valid <= 1'b1;
        in_cmd   <= cur_event.cmd;
        in_pin_a <= cur_event.pin_a;
        in_pin_b <= cur_event.pin_b;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // result side: check each transaction, stall on a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          report_error("result with no expected reading");
        end else begin
          seen_reading = reading_q.pop_front();
          if (out_tick_count !== seen_reading.count) begin
            report_error($sformatf("tick_count got %0d want %0d",
                                   $signed(out_tick_count), $signed(seen_reading.count)));
          end
          if (out_speed_rps !== seen_reading.speed) begin
            report_error($sformatf("speed_rps got %0d want %0d",
                                   $signed(out_speed_rps), $signed(seen_reading.speed)));
          end
          if (out_speed_updated !== seen_reading.updated) begin
            report_error($sformatf("speed_updated got %0b want %0b",
                                   out_speed_updated, seen_reading.updated));
          end
        end
        result_count++;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left <= $urandom_range(16, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int tpr_tab [8];
    int per_tab [8];
    tpr_tab = '{1, 65535, 3, 65535, 100, 1, 0, 0};
    per_tab = '{1, 1, 7, 65535, 5, 2, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings
    add_random_events(120);
    wait_idle();

    // zero writes are stored as one: every tick recomputes
    load_config('0, '0);
    push_event(ecsm_pkg::CMD_NONE, 1'b1, 1'b1);
    push_event(ecsm_pkg::CMD_EDGE, 1'b1, 1'b1);
    push_event(ecsm_pkg::CMD_EDGE, 1'b0, 1'b0);
    push_event(ecsm_pkg::CMD_TICK, 1'b0, 1'b1);
    push_event(ecsm_pkg::CMD_EDGE, 1'b0, 1'b1);
    push_event(ecsm_pkg::CMD_EDGE, 1'b1, 1'b0);
    push_event(ecsm_pkg::CMD_EDGE, 1'b1, 1'b0);
    push_event(ecsm_pkg::CMD_TICK, 1'b1, 1'b1);
    push_event(ecsm_pkg::CMD_NONE, 1'b0, 1'b0);
    push_event(ecsm_pkg::CMD_TICK, 1'b1, 1'b0);
    push_event(ecsm_pkg::CMD_CLEAR, 1'b1, 1'b1);
    push_event(ecsm_pkg::CMD_EDGE, 1'b1, 1'b1);
    push_event(ecsm_pkg::CMD_TICK, 1'b0, 1'b0);
    push_event(ecsm_pkg::CMD_CLEAR, 1'b0, 1'b1);
    push_event(ecsm_pkg::CMD_NONE, 1'b1, 1'b0);
    push_event(ecsm_pkg::CMD_TICK, 1'b0, 1'b0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        tpr_tab[p] = $urandom_range(1, 65535);
        per_tab[p] = $urandom_range(1, 40);
      end
      load_config(ecsm_pkg::CFG_W'(tpr_tab[p]), ecsm_pkg::CFG_W'(per_tab[p]));
      add_random_events(130);
      wait_idle();
    end

    repeat (80) @(posedge clk);
    if (reading_q.size() != 0) begin
      report_error($sformatf("%0d expected readings never arrived", reading_q.size()));
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
